/* design/fba_pkg.sv */
package fba_pkg;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned CountCfgW = 11;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned StatusW   = 2;

  typedef logic [StatusW-1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EXHAUSTED = 2'd1;
  localparam status_t ST_BAD_FREE  = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_POOL_SIZE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE_ADDR  = 2'd2;

  localparam logic [SizeW-1:0] ResetBlockSize = 16'd512;
  localparam logic [AddrW-1:0] ResetBaseAddr  = 32'd0;
  localparam int unsigned      ResetBlockCnt  = 1024;

endpackage

/* design/fixed_block_pool_allocator_top.sv */
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o   | in_cmd_i, in_block_index_i
// out     | output    | out_valid_o / out_ready_i | status, granted index/address, used
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// an allocate reads the next-head link from the link memory, then updates the
// head in S_READ; a free or a rejected command skips the read state.
// reset (async, active low) or a pool size write starts a pass over every entry
// that fills the link memory; no command is taken during the pass.
// a new command is taken while the output register holds a result only if
// that result is taken in the same cycle.
module fixed_block_pool_allocator_top
  import fba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_cmd_i,
  input  logic [$clog2(MAX_BLOCKS)-1:0] in_block_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output status_t                     out_status_o,
  output logic [$clog2(MAX_BLOCKS)-1:0] out_granted_index_o,
  output logic [AddrW-1:0]            out_granted_address_o,
  output logic [$clog2(MAX_BLOCKS+1)-1:0] out_used_blocks_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i
);

  localparam int unsigned IdxW  = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ProdW = IdxW + SizeW;
  localparam int unsigned ResetPool =
    (ResetBlockCnt > MAX_BLOCKS) ? MAX_BLOCKS : ResetBlockCnt;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;

  // control state
  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] init_q, init_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] pool_q, pool_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [AddrW-1:0] base_q, base_d;
  logic            out_valid_q, out_valid_d;

  // payload
  status_t          status_q, status_d;
  logic [IdxW-1:0]  gidx_q, gidx_d;
  logic [AddrW-1:0] gaddr_q, gaddr_d;
  logic [CntW-1:0]  oused_q, oused_d;
  logic [ProdW-1:0] prod_q, prod_d;

  // link memory
  logic [IdxW-1:0] link_mem [MAX_BLOCKS];
  logic [IdxW-1:0] link_rdata_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_wdata;

  logic            in_acc, cfg_acc, out_acc;
  logic            alloc_ok, free_ok;
  logic [CntW-1:0] cfg_blocks;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;

  assign alloc_ok = (in_cmd_i == CMD_ALLOC) && (used_q < pool_q);
  assign free_ok  = (in_cmd_i == CMD_FREE) && (CntW'(in_block_index_i) < pool_q) &&
                    (used_q != '0);

  // the fill pass links every entry to the one below it, entry 0 to itself
  assign mem_we    = (state_q == S_INIT) || (in_acc && free_ok);
  assign mem_waddr = (state_q == S_INIT) ? init_q : in_block_index_i;
  assign mem_wdata = (state_q == S_INIT) ?
                     ((init_q == '0) ? '0 : init_q - IdxW'(1)) : head_q;
  assign mem_re    = in_acc && alloc_ok;

  // saturate the written block count to the pool capacity
  assign cfg_blocks = (cfg_data_i[CountCfgW-1:0] > MAX_BLOCKS) ?
                      CntW'(MAX_BLOCKS) : CntW'(cfg_data_i[CountCfgW-1:0]);

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    head_d      = head_q;
    used_d      = used_q;
    pool_d      = pool_q;
    size_d      = size_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    gidx_d      = gidx_q;
    gaddr_d     = gaddr_q;
    oused_d     = oused_q;
    prod_d      = prod_q;

    if (state_q == S_INIT) begin
      init_d = init_q + IdxW'(1);
      if (init_q == IdxW'(MAX_BLOCKS - 1)) begin
        state_d = S_IDLE;
      end
    end

    if (in_acc) begin
      if (in_cmd_i == CMD_ALLOC) begin
        if (alloc_ok) begin
          state_d = S_READ;
          gidx_d  = head_q;
          prod_d  = ProdW'(head_q) * ProdW'(size_q);
        end else begin
          out_valid_d = 1'b1;
          status_d    = ST_EXHAUSTED;
          gidx_d      = '0;
          gaddr_d     = '0;
          oused_d     = used_q;
        end
      end else begin
        out_valid_d = 1'b1;
        gidx_d      = '0;
        gaddr_d     = '0;
        if (free_ok) begin
          status_d = ST_OK;
          head_d   = in_block_index_i;
          used_d   = used_q - CntW'(1);
          oused_d  = used_q - CntW'(1);
        end else begin
          status_d = ST_BAD_FREE;
          oused_d  = used_q;
        end
      end
    end

    if (state_q == S_READ) begin
      // link data of the popped block is now valid
      state_d     = S_IDLE;
      head_d      = link_rdata_q;
      used_d      = used_q + CntW'(1);
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      gaddr_d     = base_q + AddrW'(prod_q);
      oused_d     = used_q + CntW'(1);
    end

    if (cfg_acc) begin
      case (cfg_index_i)
        REG_POOL_SIZE: begin
          pool_d  = cfg_blocks;
          used_d  = '0;
          head_d  = (cfg_blocks == '0) ? '0 : IdxW'(cfg_blocks - CntW'(1));
          state_d = S_INIT;
          init_d  = '0;
        end
        REG_BLOCK_SIZE: size_d = cfg_data_i[SizeW-1:0];
        REG_BASE_ADDR:  base_d = cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      head_q      <= IdxW'(ResetPool - 1);
      used_q      <= '0;
      pool_q      <= CntW'(ResetPool);
      size_q      <= ResetBlockSize;
      base_q      <= ResetBaseAddr;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      head_q      <= head_d;
      used_q      <= used_d;
      pool_q      <= pool_d;
      size_q      <= size_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    gidx_q   <= gidx_d;
    gaddr_q  <= gaddr_d;
    oused_q  <= oused_d;
    prod_q   <= prod_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rdata_q <= link_mem[head_q];
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_status_o          = status_q;
  assign out_granted_index_o   = gidx_q;
  assign out_granted_address_o = gaddr_q;
  assign out_used_blocks_o     = oused_q;

`ifndef SYNTHESIS
  a_used_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= pool_q)
    else $error("used count above pool size");

  a_alloc_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && alloc_ok && !out_acc) |=> (state_q == S_READ) && !out_valid_q)
    else $error("allocate did not enter read cycle with a free output register");

  a_alloc_read_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && alloc_ok) |=> (state_q == S_READ) && !in_ready_o)
    else $error("command taken during link read");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != ST_OK) |->
      (out_granted_index_o == '0) && (out_granted_address_o == '0))
    else $error("rejected command carries a grant");
`endif

endmodule

/* bench/testbench.sv */
module testbench;
  import fba_pkg::*;

  localparam int unsigned MaxBlocks  = 1024;
  localparam int unsigned IdxW       = $clog2(MaxBlocks);
  localparam int unsigned UsedW      = $clog2(MaxBlocks + 1);
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 120;
  localparam int unsigned NumPhases  = 12;

  // register index that the block has no register for
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    status_t              status;
    logic [IdxW-1:0]      index;
    logic [AddrW-1:0]     addr;
    logic [UsedW-1:0]     used;
  } grant_t;

  class pool_tracker;
    logic [UsedW-1:0]     links [MaxBlocks];
    bit                   taken [MaxBlocks];
    logic [UsedW-1:0]     head;
    int unsigned          used;
    int unsigned          pool_n;
    logic [CountCfgW-1:0] count_reg;
    logic [SizeW-1:0]     size_reg;
    logic [AddrW-1:0]     base_reg;
    grant_t               due_grants [$];
    int                   mismatches;

    function new();
      count_reg  = CountCfgW'(ResetBlockCnt);
      size_reg   = ResetBlockSize;
      base_reg   = ResetBaseAddr;
      mismatches = 0;
      rebuild();
    endfunction

    // free list holds pool_n-1 down to 0, head at the top
    function void rebuild();
      pool_n   = (count_reg > MaxBlocks) ? MaxBlocks : count_reg;
      links[0] = '0;
      for (int i = 1; i < MaxBlocks; i++) links[i] = UsedW'(i - 1);
      head = (pool_n > 0) ? UsedW'(pool_n - 1) : '0;
      used = 0;
      foreach (taken[i]) taken[i] = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_POOL_SIZE: begin
          count_reg = data[CountCfgW-1:0];
          rebuild();
        end
        REG_BLOCK_SIZE: size_reg = data[SizeW-1:0];
        REG_BASE_ADDR:  base_reg = data[AddrW-1:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic cmd, logic [IdxW-1:0] idx);
      grant_t           g;
      logic [UsedW-1:0] nxt;
      g = '0;
      if (cmd == CMD_ALLOC) begin
        if (used >= pool_n) begin
          g.status = ST_EXHAUSTED;
        end else begin
          nxt      = links[head];
          g.status = ST_OK;
          g.index  = head[IdxW-1:0];
          g.addr   = base_reg + AddrW'(head) * AddrW'(size_reg);
          taken[head] = 1'b1;
          head = (nxt < MaxBlocks) ? nxt : '0;
          used++;
        end
      end else begin
        if (idx >= pool_n || used == 0) begin
          g.status = ST_BAD_FREE;
        end else begin
          links[idx] = head;
          head       = UsedW'(idx);
          taken[idx] = 1'b0;
          used--;
        end
      end
      g.used = UsedW'(used);
      due_grants.push_back(g);
    endfunction

    // some block currently handed out, or -1 if none is known
    function int pick_taken();
      int start;
      int j;
      start = $urandom_range(0, MaxBlocks - 1);
      for (int k = 0; k < MaxBlocks; k++) begin
        j = (start + k) % MaxBlocks;
        if (taken[j]) return j;
      end
      return -1;
    endfunction

    function void check_grant(status_t st, logic [IdxW-1:0] gi, logic [AddrW-1:0] ga,
                              logic [UsedW-1:0] u);
      grant_t want;
      if (due_grants.size() == 0) begin
        $display("%0t: result with no command outstanding: status %0d index %0d used %0d",
                 $time, st, gi, u);
        mismatches++;
        return;
      end
      want = due_grants.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        mismatches++;
      end
      if (gi !== want.index) begin
        $display("%0t: granted index expected %0d actual %0d", $time, want.index, gi);
        mismatches++;
      end
      if (ga !== want.addr) begin
        $display("%0t: granted address expected %h actual %h", $time, want.addr, ga);
        mismatches++;
      end
      if (u !== want.used) begin
        $display("%0t: used blocks expected %0d actual %0d", $time, want.used, u);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  logic                 in_cmd_i         = CMD_ALLOC;
  logic [IdxW-1:0]      in_block_index_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  status_t              out_status_o;
  logic [IdxW-1:0]      out_granted_index_o;
  logic [AddrW-1:0]     out_granted_address_o;
  logic [UsedW-1:0]     out_used_blocks_o;
  logic                 cfg_valid_i      = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i      = '0;
  logic [CfgDataW-1:0]  cfg_data_i       = '0;

  int unsigned          cycle_count   = 0;
  int unsigned          in_idle_pct   = 0;
  int unsigned          out_stall_pct = 0;
  pool_tracker          tracker;

  fixed_block_pool_allocator_top #(
    .MAX_BLOCKS(MaxBlocks)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .in_cmd_i             (in_cmd_i),
    .in_block_index_i     (in_block_index_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_status_o         (out_status_o),
    .out_granted_index_o  (out_granted_index_o),
    .out_granted_address_o(out_granted_address_o),
    .out_used_blocks_o    (out_used_blocks_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_grant(out_status_o, out_granted_index_o, out_granted_address_o,
                          out_used_blocks_o);
    end
  end

  task automatic send_cmd(logic c, logic [IdxW-1:0] i);
    in_valid_i       <= 1'b1;
    in_cmd_i         <= c;
    in_block_index_i <= i;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    tracker.note_command(c, i);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
  endtask

  // hold off the sender until every outstanding transaction has its result
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.due_grants.size() != 0);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    drain();
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    tracker.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n_items);
    int              j;
    int              bias;
    logic            c;
    logic [IdxW-1:0] i;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) drain();
      // swing between filling and emptying the pool
      bias = ((k / 24) % 2 == 0) ? 78 : 30;
      i    = IdxW'($urandom_range(0, MaxBlocks - 1));
      if ($urandom_range(99) < 82) begin
        if (tracker.used == 0) c = CMD_ALLOC;
        else if (tracker.used >= tracker.pool_n)
          c = ($urandom_range(99) < 25) ? CMD_ALLOC : CMD_FREE;
        else
          c = ($urandom_range(99) < bias) ? CMD_ALLOC : CMD_FREE;
        if (c == CMD_FREE) begin
          j = tracker.pick_taken();
          if (j >= 0) i = IdxW'(j);
        end
      end else begin
        c = logic'($urandom_range(0, 1));
      end
      send_cmd(c, i);
    end
  endtask

  initial begin
    logic [CountCfgW-1:0] count_val;
    logic [SizeW-1:0]     size_val;
    logic [AddrW-1:0]     base_val;
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default pool of 1024 blocks
    send_cmd(CMD_FREE, 10'd0);      // nothing handed out yet
    send_cmd(CMD_ALLOC, '1);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_FREE, 10'd1023);
    send_cmd(CMD_FREE, 10'd1023);   // double free while one block is out
    send_cmd(CMD_FREE, 10'd1022);

    // empty pool
    cfg_write(REG_POOL_SIZE, 32'd0);
    send_cmd(CMD_ALLOC, 10'd0);
    send_cmd(CMD_FREE, 10'd0);
    send_cmd(CMD_FREE, '1);

    // single block
    cfg_write(REG_POOL_SIZE, 32'd1);
    send_cmd(CMD_ALLOC, 10'd5);
    send_cmd(CMD_ALLOC, 10'd0);
    send_cmd(CMD_FREE, 10'd1);      // out of range
    send_cmd(CMD_FREE, 10'd0);
    send_cmd(CMD_FREE, 10'd0);

    // oversized count saturates, address wraps at 32 bits
    cfg_write(REG_BLOCK_SIZE, 32'hFFFF_FFFF);
    cfg_write(REG_BASE_ADDR, 32'hFFFF_FFFF);
    cfg_write(REG_POOL_SIZE, 32'hFFFF_FFFF);
    send_cmd(CMD_ALLOC, 10'h155);
    send_cmd(CMD_ALLOC, 10'h2AA);
    send_cmd(CMD_FREE, 10'd1023);
    cfg_write(RegSpare, $urandom);
    send_cmd(CMD_ALLOC, 10'd0);

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 6)
        0:       count_val = 11'd1;
        1:       count_val = 11'($urandom_range(2, 8));
        2:       count_val = 11'($urandom_range(9, 40));
        3:       count_val = 11'd1024;
        4:       count_val = 11'h7FF;
        default: count_val = 11'($urandom_range(41, 200));
      endcase
      case (p % 3)
        0:       size_val = 16'hFFFF;
        1:       size_val = 16'd1;
        default: size_val = 16'($urandom_range(2, 65534));
      endcase
      case ((p + 1) % 3)
        0:       base_val = 32'd0;
        1:       base_val = 32'hFFFF_FFFF;
        default: base_val = $urandom;
      endcase
      cfg_write(REG_BLOCK_SIZE, {16'($urandom), size_val});
      cfg_write(REG_BASE_ADDR, base_val);
      cfg_write(REG_POOL_SIZE, {21'($urandom), count_val});
      if (p % 2 == 1) cfg_write(RegSpare, $urandom);
      case (p % 4)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 67; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 67; end
        default: begin in_idle_pct = 34; out_stall_pct = 34; end
      endcase
      run_random(PhaseItems);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due_grants.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
